// ===== rtl/ats_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

  localparam int unsigned STACK_FRAMES   = 512;
  localparam int unsigned ARGUMENT_SLOTS = 128;

  localparam int unsigned DEPTH_W = $clog2(STACK_FRAMES + 1);
  localparam int unsigned IDX_W   = $clog2(STACK_FRAMES);
  localparam int unsigned SLOT_W  = $clog2(ARGUMENT_SLOTS);
  localparam int unsigned ADDR_W  = 64;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_POISON   = 3'd2,
    OP_UNPOISON = 3'd3,
    OP_QUERY    = 3'd4,
    OP_ONCE     = 3'd5,
    OP_CLEAR    = 3'd6,
    OP_NOP      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/ats_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ats_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [63:0]        function_address;
  logic signed [7:0]  argument_position;

  modport source (output valid, func, function_address, argument_position, input ready);
  modport sink   (input valid, func, function_address, argument_position, output ready);
endinterface

`default_nettype wire

// ===== rtl/ats_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ats_rsp_if;
  logic       valid;
  logic       ready;
  logic       poisoned;
  logic [1:0] status;

  modport source (output valid, poisoned, status, input ready);
  modport sink   (input valid, poisoned, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/ats_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ats_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/argument_taint_shadow_stack.sv =====
// Channel  Modport  Direction  Payload
// req_i    sink     in         func, function_address, argument_position
// rsp_o    source   out        poisoned, status
//
// Only a pop that leaves a frame on the stack enters the load state, in which no request
// is taken and the new top frame is read back from the frame memories.
// The top frame lives in registers; the memories hold the frames below it.
// Reset clears the depth and the handshake state; the memories need no clearing.
// A stalled response register holds back further transactions until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module argument_taint_shadow_stack (
  input wire logic clk_i,
  input wire logic rst_ni,
  ats_req_if.sink   req_i,
  ats_rsp_if.source rsp_o
);
  import ats_pkg::*;

  state_e                    state_q, state_d;
  logic [DEPTH_W-1:0]        depth_q, depth_d;
  logic [ADDR_W-1:0]         top_addr_q, top_addr_d;
  logic [ARGUMENT_SLOTS-1:0] top_poison_q, top_poison_d;
  logic                      rsp_valid_q, rsp_valid_d;
  logic                      rsp_poisoned_q, rsp_poisoned_d;
  status_e                   rsp_status_q, rsp_status_d;

  logic                      req_fire;
  logic                      have;
  logic                      match;
  logic signed [8:0]         slot_ext;
  logic                      slot_ok;
  logic [SLOT_W-1:0]         slot_idx;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [IDX_W-1:0]          mem_raddr;
  logic [ADDR_W-1:0]         addr_rdata;
  logic [ARGUMENT_SLOTS-1:0] poison_rdata;

  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;

  assign have     = (depth_q != '0);
  assign match    = have && (top_addr_q == req_i.function_address);
  assign slot_ext = $signed({req_i.argument_position[7], req_i.argument_position}) + 9'sd1;
  assign slot_ok  = !slot_ext[8] && ({1'b0, slot_ext} < 10'(ARGUMENT_SLOTS));
  assign slot_idx = slot_ext[SLOT_W-1:0];

  assign mem_waddr = IDX_W'(depth_q - DEPTH_W'(1));
  assign mem_raddr = IDX_W'(depth_q - DEPTH_W'(2));

  always_comb begin
    state_d        = state_q;
    depth_d        = depth_q;
    top_addr_d     = top_addr_q;
    top_poison_d   = top_poison_q;
    rsp_valid_d    = rsp_valid_q && !rsp_o.ready;
    rsp_poisoned_d = rsp_poisoned_q;
    rsp_status_d   = rsp_status_q;
    mem_we         = 1'b0;

    if (state_q == S_LOAD) begin
      top_addr_d   = addr_rdata;
      top_poison_d = poison_rdata;
      state_d      = S_IDLE;
    end

    if (req_fire) begin
      rsp_valid_d    = 1'b1;
      rsp_poisoned_d = 1'b0;
      rsp_status_d   = ST_OK;
      case (op_e'(req_i.func))
        OP_PUSH: begin
          if (depth_q == DEPTH_W'(STACK_FRAMES)) begin
            rsp_status_d = ST_FULL;
          end else begin
            mem_we       = have;
            top_addr_d   = req_i.function_address;
            top_poison_d = '0;
            depth_d      = depth_q + DEPTH_W'(1);
          end
        end
        OP_POP: begin
          if (!have) begin
            rsp_status_d = ST_EMPTY;
          end else begin
            depth_d      = depth_q - DEPTH_W'(1);
            rsp_status_d = match ? ST_OK : ST_MISMATCH;
            if (depth_q > DEPTH_W'(1)) begin
              state_d = S_LOAD;
            end
          end
        end
        OP_POISON: begin
          if (!match) begin
            rsp_status_d = ST_MISMATCH;
          end else if (slot_ok) begin
            top_poison_d[slot_idx] = 1'b1;
          end
        end
        OP_UNPOISON, OP_ONCE: begin
          if (!have) begin
            rsp_status_d = ST_EMPTY;
          end else begin
            if (slot_ok) begin
              if (op_e'(req_i.func) == OP_ONCE && match) begin
                rsp_poisoned_d = top_poison_q[slot_idx];
              end
              top_poison_d[slot_idx] = 1'b0;
            end
            rsp_status_d = match ? ST_OK : ST_MISMATCH;
          end
        end
        OP_QUERY: begin
          if (!match) begin
            rsp_status_d = ST_MISMATCH;
          end else if (slot_ok) begin
            rsp_poisoned_d = top_poison_q[slot_idx];
          end
        end
        OP_CLEAR: begin
          if (!have) begin
            rsp_status_d = ST_EMPTY;
          end else begin
            top_poison_d = '0;
            rsp_status_d = match ? ST_OK : ST_MISMATCH;
          end
        end
        default: begin
        end
      endcase
    end
  end

  ats_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (STACK_FRAMES)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (top_addr_q),
    .raddr_i (mem_raddr),
    .rdata_o (addr_rdata)
  );

  ats_ram #(
    .WIDTH (ARGUMENT_SLOTS),
    .DEPTH (STACK_FRAMES)
  ) u_poison_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (top_poison_q),
    .raddr_i (mem_raddr),
    .rdata_o (poison_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_addr_q     <= top_addr_d;
    top_poison_q   <= top_poison_d;
    rsp_poisoned_q <= rsp_poisoned_d;
    rsp_status_q   <= rsp_status_d;
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.poisoned = rsp_poisoned_q;
  assign rsp_o.status   = rsp_status_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_FRAMES))
    else $error("stack depth exceeds the frame count");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && op_e'(req_i.func) == OP_PUSH && depth_q != DEPTH_W'(STACK_FRAMES)
    |=> depth_q == $past(depth_q) + DEPTH_W'(1))
    else $error("accepted push did not grow the stack");

  a_pop_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && op_e'(req_i.func) == OP_POP && depth_q > DEPTH_W'(1)
    |=> state_q == S_LOAD && !req_i.ready)
    else $error("pop did not reload the top frame");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> rsp_o.valid)
    else $error("accepted transaction produced no response");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && op_e'(req_i.func) == OP_PUSH && depth_q == DEPTH_W'(STACK_FRAMES)
    |=> $stable(depth_q) && rsp_o.status == ST_FULL)
    else $error("push onto a full stack was not refused");

endmodule

`default_nettype wire
